// ===== hdl/lwsam_pkg.sv =====
// ----------------------------------------------------------------------------
// lwsam_pkg
// Shared constants and controller/datapath interface types for the
// longest-window-sum block.
// ----------------------------------------------------------------------------
package lwsam_pkg;

	localparam int unsigned MAX_ITEMS_DEF  = 1024;
	localparam int unsigned VALUE_BITS_DEF = 16;

	localparam int unsigned VALUE_W = 16;
	localparam int unsigned LIMIT_W = 32;
	localparam int unsigned BEST_W  = 11;
	localparam int unsigned TDATA_W = 16;

	// controller to datapath
	typedef struct packed {
		logic take;   // beat accepted: store value, grow the window
		logic rd;     // read the oldest window entry
		logic sub;    // drop the oldest entry from the window
		logic fin;    // finish the item: best length, result, frame clear
	} lwsam_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic shrink; // window sum above limit with entries left to drop
	} lwsam_status_t;

endpackage

// ===== hdl/lwsam_ctrl.sv =====
// ----------------------------------------------------------------------------
// lwsam_ctrl
// Sequencer: accepts one beat, shrinks the window one entry at a time and
// hands the result to the output register.
// ----------------------------------------------------------------------------
module lwsam_ctrl (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    s_tvalid,
	output logic                    s_tready,
	output logic                    m_tvalid,
	input  logic                    m_tready,
	input  lwsam_pkg::lwsam_status_t status,
	output lwsam_pkg::lwsam_cmd_t    cmd
);
	import lwsam_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EVAL,
		ST_SUB
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;
	assign out_free = !out_valid_q || m_tready;

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE: cmd.take = s_tvalid;
			ST_EVAL: begin
				cmd.rd  = status.shrink;
				cmd.fin = !status.shrink && out_free;
			end
			ST_SUB: cmd.sub = 1'b1;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.fin) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: if (s_tvalid) begin
					state_q <= ST_EVAL;
				end
				ST_EVAL: begin
					if (status.shrink) begin
						state_q <= ST_SUB;
					end else if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				ST_SUB: state_q <= ST_EVAL;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== hdl/lwsam_dpath.sv =====
// ----------------------------------------------------------------------------
// lwsam_dpath
// Window store, running sum, window start, counts, limit register and the
// result register.
// ----------------------------------------------------------------------------
module lwsam_dpath #(
	parameter int unsigned MAX_ITEMS  = lwsam_pkg::MAX_ITEMS_DEF,
	parameter int unsigned VALUE_BITS = lwsam_pkg::VALUE_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [lwsam_pkg::VALUE_W-1:0]    value,
	input  logic                             last_item,
	input  logic                             sum_limit_we,
	input  logic [lwsam_pkg::LIMIT_W-1:0]    sum_limit_wdata,
	input  lwsam_pkg::lwsam_cmd_t            cmd,
	output lwsam_pkg::lwsam_status_t         status,
	output logic [lwsam_pkg::BEST_W-1:0]     best_length,
	output logic                             too_long
);
	import lwsam_pkg::*;

	localparam int unsigned IDX_W = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
	localparam int unsigned CNT_W = $clog2(MAX_ITEMS + 1);
	localparam int unsigned SUM_W = VALUE_BITS + IDX_W;
	localparam int unsigned CMP_W = (SUM_W > LIMIT_W) ? SUM_W : LIMIT_W;

	logic [VALUE_BITS-1:0] mem [MAX_ITEMS];
	logic [VALUE_BITS-1:0] rdata_q;

	logic [LIMIT_W-1:0] sum_limit_q;
	logic [SUM_W-1:0]   sum_q;
	logic [CNT_W-1:0]   start_q;
	logic [CNT_W-1:0]   items_q;
	logic [CNT_W-1:0]   best_q;
	logic               overflowed_q;
	logic               skip_q;
	logic               last_q;
	logic [BEST_W-1:0]  best_length_q;
	logic               too_long_q;

	logic [VALUE_BITS-1:0] v;
	logic                  full;
	logic                  over_limit;
	logic [CNT_W-1:0]      len;
	logic [CNT_W-1:0]      best_new;

	assign v          = VALUE_BITS'(value);
	assign full       = (items_q >= CNT_W'(MAX_ITEMS));
	assign over_limit = CMP_W'(sum_q) > CMP_W'(sum_limit_q);
	// window is start_q..items_q inclusive of the newest entry at index items_q
	assign status.shrink = !skip_q && over_limit && (start_q <= items_q);
	assign len        = items_q + CNT_W'(1) - start_q;
	assign best_new   = (!skip_q && !over_limit && len > best_q) ? len : best_q;

	assign best_length = best_length_q;
	assign too_long    = too_long_q;

	always_ff @(posedge clk) begin
		if (cmd.take && !full) begin
			mem[items_q[IDX_W-1:0]] <= v;
		end
		if (cmd.rd) begin
			rdata_q <= mem[start_q[IDX_W-1:0]];
		end
		if (cmd.fin) begin
			best_length_q <= BEST_W'(best_new);
			too_long_q    <= overflowed_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_limit_q  <= '0;
			sum_q        <= '0;
			start_q      <= '0;
			items_q      <= '0;
			best_q       <= '0;
			overflowed_q <= 1'b0;
			skip_q       <= 1'b0;
			last_q       <= 1'b0;
		end else begin
			if (sum_limit_we) begin
				sum_limit_q <= sum_limit_wdata;
			end
			if (cmd.take) begin
				last_q <= last_item;
				skip_q <= full;
				if (full) begin
					overflowed_q <= 1'b1;
				end else begin
					sum_q <= sum_q + SUM_W'(v);
				end
			end
			if (cmd.sub) begin
				sum_q   <= sum_q - SUM_W'(rdata_q);
				start_q <= start_q + CNT_W'(1);
			end
			if (cmd.fin) begin
				if (last_q) begin
					// end of array: clear sum, window start, count, best and overflow, not the limit
					sum_q        <= '0;
					start_q      <= '0;
					items_q      <= '0;
					best_q       <= '0;
					overflowed_q <= 1'b0;
				end else if (!skip_q) begin
					items_q <= items_q + CNT_W'(1);
					best_q  <= best_new;
				end
			end
		end
	end

endmodule

// ===== hdl/longest_window_sum_at_most.sv =====
// one result beat per input beat; an accepted beat moves from ST_IDLE to ST_EVAL,
// each drop passes ST_SUB back to ST_EVAL, and the result is registered on
// leaving ST_EVAL once the output register is free; a new beat is taken only in
// ST_IDLE; drops run one at a time, set by the single read port of the window
// store (registered read, then subtract); arst_n clears control, sums, counts and
// the limit (to 0) at once; the window store is not cleared and needs no pass
// ----------------------------------------------------------------------------
// longest_window_sum_at_most
// Longest contiguous window of a value stream whose sum stays at or below a
// configured limit, tracked per array framed by tlast.
// ----------------------------------------------------------------------------
module longest_window_sum_at_most #(
	parameter int unsigned MAX_ITEMS  = lwsam_pkg::MAX_ITEMS_DEF,
	parameter int unsigned VALUE_BITS = lwsam_pkg::VALUE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [lwsam_pkg::TDATA_W-1:0] s_tdata,  // [15:0] value
	input  logic                          s_tlast,  // last_item
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [lwsam_pkg::TDATA_W-1:0] m_tdata,  // [10:0] best_length, rest zero
	output logic                          m_tuser,  // too_long
	input  logic                          sum_limit_we,
	input  logic [lwsam_pkg::LIMIT_W-1:0] sum_limit_wdata
);
	import lwsam_pkg::*;

	lwsam_cmd_t          cmd;
	lwsam_status_t       status;
	logic [BEST_W-1:0]   best_length;

	lwsam_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.status   (status),
		.cmd      (cmd)
	);

	lwsam_dpath #(
		.MAX_ITEMS  (MAX_ITEMS),
		.VALUE_BITS (VALUE_BITS)
	) u_dpath (
		.clk             (clk),
		.arst_n          (arst_n),
		.value           (s_tdata[VALUE_W-1:0]),
		.last_item       (s_tlast),
		.sum_limit_we    (sum_limit_we),
		.sum_limit_wdata (sum_limit_wdata),
		.cmd             (cmd),
		.status          (status),
		.best_length     (best_length),
		.too_long        (m_tuser)
	);

	assign m_tdata = TDATA_W'(best_length);

endmodule

// ===== hdl/lwsam_checker.sv =====
// ----------------------------------------------------------------------------
// lwsam_checker
// Port-level checks for longest_window_sum_at_most, bound to the top level.
// ----------------------------------------------------------------------------
module lwsam_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [lwsam_pkg::TDATA_W-1:0] m_tdata,
	input logic                          m_tuser
);
	import lwsam_pkg::*;

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result beat changed while stalled");

	// s_tready drops after every accepted input beat
	a_no_b2b: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted on consecutive cycles");

	// m_tvalid stays low just after a beat is accepted with no result pending
	a_min_lat: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && !m_tvalid |=> !m_tvalid)
		else $error("result appeared one cycle after accept");

	// padding above best_length stays zero
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[TDATA_W-1:BEST_W] == '0)
		else $error("nonzero padding in result beat");

endmodule

bind longest_window_sum_at_most lwsam_checker u_lwsam_checker (.*);

// ===== sim/tb_longest_window_sum_at_most.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_longest_window_sum_at_most
// Drives framed value streams into the longest-window-sum block under several
// limits and handshake idling patterns. A window predictor in the bench
// tracks the ring, sum and best length, and every result beat is compared
// with the oldest pending expected result.
// ----------------------------------------------------------------------------
module tb_longest_window_sum_at_most;

	import lwsam_pkg::*;

	localparam int unsigned DEPTH      = MAX_ITEMS_DEF;
	localparam int unsigned HOLD_BEATS = 400;

	typedef struct packed {
		logic [BEST_W-1:0] best;
		logic              too_long;
	} window_result_t;

	typedef struct packed {
		logic              wr_limit;
		logic [LIMIT_W-1:0] limit;
		logic [VALUE_W-1:0] value;
		logic              last;
		logic              known;
		logic [BEST_W-1:0] best;
		logic              too_long;
	} directed_row_t;

	logic               clk;
	logic               arst_n          = 1'b0;
	logic               s_tvalid        = 1'b0;
	logic               s_tready;
	logic [TDATA_W-1:0] s_tdata         = '0;  // [15:0] value
	logic               s_tlast         = 1'b0; // last_item
	logic               m_tvalid;
	logic               m_tready        = 1'b0;
	logic [TDATA_W-1:0] m_tdata;                // [10:0] best_length, rest zero
	logic               m_tuser;                // too_long
	logic               sum_limit_we    = 1'b0;
	logic [LIMIT_W-1:0] sum_limit_wdata = '0;

	// window predictor state
	logic [VALUE_W-1:0] win_ring [0:DEPTH-1];
	longint unsigned    win_sum      = 0;
	int unsigned        win_head     = 0;
	int unsigned        win_count    = 0;
	logic [BEST_W-1:0]  win_best     = '0;
	bit                 win_ovf      = 1'b0;
	logic [LIMIT_W-1:0] limit_shadow = '0;

	window_result_t expected_windows [$];

	int unsigned mismatches    = 0;
	int unsigned results_seen  = 0;
	int unsigned src_idle_pct  = 0;
	int unsigned snk_stall_pct = 0;
	int unsigned value_cap     = 3;
	int unsigned frame_left    = 0;
	int unsigned hold_left     = 0;
	bit          hold_req      = 1'b0;

	directed_row_t directed_rows [0:16] = '{
		// limit 0 from reset: zeros fit, a big value empties the window
		'{1'b0, 32'd0,          16'h0000, 1'b0, 1'b1, 11'd1, 1'b0},
		'{1'b0, 32'd0,          16'h0000, 1'b0, 1'b1, 11'd2, 1'b0},
		'{1'b0, 32'd0,          16'hFFFF, 1'b1, 1'b1, 11'd2, 1'b0},
		// widest limit, largest values
		'{1'b1, 32'hFFFF_FFFF,  16'hFFFF, 1'b0, 1'b1, 11'd1, 1'b0},
		'{1'b0, 32'd0,          16'hFFFF, 1'b1, 1'b1, 11'd2, 1'b0},
		'{1'b1, 32'd100,        16'd100,  1'b0, 1'b0, 11'd0, 1'b0},
		'{1'b0, 32'd0,          16'd1,    1'b0, 1'b0, 11'd0, 1'b0},
		'{1'b0, 32'd0,          16'd99,   1'b0, 1'b0, 11'd0, 1'b0},
		'{1'b0, 32'd0,          16'd101,  1'b1, 1'b0, 11'd0, 1'b0},
		// lone value above the limit leaves an empty window
		'{1'b1, 32'd5,          16'd6,    1'b0, 1'b1, 11'd0, 1'b0},
		'{1'b0, 32'd0,          16'd2,    1'b0, 1'b0, 11'd0, 1'b0},
		'{1'b0, 32'd0,          16'd3,    1'b0, 1'b0, 11'd0, 1'b0},
		'{1'b0, 32'd0,          16'd0,    1'b0, 1'b0, 11'd0, 1'b0},
		'{1'b0, 32'd0,          16'd1,    1'b1, 1'b0, 11'd0, 1'b0},
		// limit changes in the middle of an array
		'{1'b1, 32'd10,         16'd7,    1'b0, 1'b0, 11'd0, 1'b0},
		'{1'b1, 32'd3,          16'd2,    1'b0, 1'b0, 11'd0, 1'b0},
		'{1'b0, 32'd0,          16'd1,    1'b1, 1'b0, 11'd0, 1'b0}
	};

	longest_window_sum_at_most u_top (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_tvalid        (s_tvalid),
		.s_tready        (s_tready),
		.s_tdata         (s_tdata),
		.s_tlast         (s_tlast),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.m_tdata         (m_tdata),
		.m_tuser         (m_tuser),
		.sum_limit_we    (sum_limit_we),
		.sum_limit_wdata (sum_limit_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("tb_longest_window_sum_at_most: FAIL");
		$finish;
	end

	function automatic window_result_t predict_window(input logic [VALUE_W-1:0] v,
			input logic last);
		window_result_t r;
		int unsigned len;
		if (win_count >= DEPTH) begin
			win_ovf = 1'b1;
		end else begin
			win_ring[win_count] = v;
			win_sum += v;
			while (win_sum > limit_shadow && win_head <= win_count) begin
				win_sum -= win_ring[win_head];
				win_head++;
			end
			len = win_count + 1 - win_head;
			if (win_sum <= limit_shadow && len > win_best)
				win_best = BEST_W'(len);
			win_count++;
		end
		r.best     = win_best;
		r.too_long = win_ovf;
		if (last) begin
			win_sum   = 0;
			win_head  = 0;
			win_count = 0;
			win_best  = '0;
			win_ovf   = 1'b0;
		end
		return r;
	endfunction

	task automatic report_mismatch(input string what, input longint unsigned got,
			input longint unsigned want);
		$display("mismatch %s at result %0d: got 0x%0h expected 0x%0h",
			what, results_seen, got, want);
		mismatches++;
	endtask

	// one beat offered until taken; valid stays up for a following beat
	task automatic drive_beat(input logic [VALUE_W-1:0] v, input logic last);
		@(negedge clk);
		while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= v;
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic drain_results();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (expected_windows.size() != 0)
			@(posedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_limit(input logic [LIMIT_W-1:0] lim);
		drain_results();
		sum_limit_we    <= 1'b1;
		sum_limit_wdata <= lim;
		@(negedge clk);
		sum_limit_we    <= 1'b0;
		limit_shadow = lim;
	endtask

	task automatic send_stream_beat();
		logic [VALUE_W-1:0] v;
		logic               last;
		if (frame_left == 0)
			frame_left = ($urandom_range(7) == 0) ? 1 : $urandom_range(40, 2);
		case ($urandom_range(9))
			0:       v = '0;
			1:       v = '1;
			2, 3:    v = VALUE_W'($urandom);
			default: v = VALUE_W'($urandom_range(value_cap, 0));
		endcase
		frame_left--;
		last = (frame_left == 0);
		drive_beat(v, last);
		expected_windows.push_back(predict_window(v, last));
	endtask

	// receiver side: random stalls plus one long hold-off on request
	always @(negedge clk) begin
		if (hold_req) begin
			hold_left = HOLD_BEATS;
			hold_req  = 1'b0;
		end
		if (hold_left != 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= !(snk_stall_pct != 0 && $urandom_range(99) < snk_stall_pct);
		end
	end

	always @(posedge clk) begin : result_check
		window_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_windows.size() == 0) begin
				report_mismatch("unexpected beat", 64'(m_tdata), 64'd0);
			end else begin
				want = expected_windows.pop_front();
				if (m_tdata !== {{(TDATA_W-BEST_W){1'b0}}, want.best})
					report_mismatch("best_length", 64'(m_tdata), 64'(want.best));
				if (m_tuser !== want.too_long)
					report_mismatch("too_long", 64'(m_tuser), 64'(want.too_long));
			end
			results_seen++;
		end
	end

	initial begin
		window_result_t got_pred;
		logic [LIMIT_W-1:0] lim;

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].wr_limit)
				write_limit(directed_rows[i].limit);
			drive_beat(directed_rows[i].value, directed_rows[i].last);
			got_pred = predict_window(directed_rows[i].value, directed_rows[i].last);
			if (directed_rows[i].known)
				expected_windows.push_back(window_result_t'{directed_rows[i].best,
					directed_rows[i].too_long});
			else
				expected_windows.push_back(got_pred);
		end

		for (int ph = 0; ph < 13; ph++) begin
			case (ph % 4)
				0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
				1: begin src_idle_pct = 52; snk_stall_pct = 0;  end
				2: begin src_idle_pct = 0;  snk_stall_pct = 52; end
				default: begin src_idle_pct = 17; snk_stall_pct = 17; end
			endcase
			if (ph == 0) begin
				lim = '0;
				value_cap = 3;
			end else if (ph == 1) begin
				lim = '1;
				value_cap = 65535;
			end else if (ph == 8) begin
				lim = 1000;
				value_cap = 60;
			end else begin
				case ($urandom_range(3))
					0: begin lim = $urandom_range(300);     value_cap = 60;    end
					1: begin lim = $urandom_range(4000);    value_cap = 400;   end
					2: begin lim = $urandom_range(1 << 20); value_cap = 65535; end
					default: begin lim = $urandom;          value_cap = 65535; end
				endcase
			end
			write_limit(lim);
			if (ph == 4)
				hold_req = 1'b1;
			if (ph == 8) begin
				// finish the open array, then one that runs past the store depth
				while (frame_left != 0)
					send_stream_beat();
				frame_left = DEPTH + $urandom_range(4, 1);
				while (frame_left != 0)
					send_stream_beat();
			end else begin
				repeat (36) send_stream_beat();
			end
		end

		@(negedge clk);
		s_tvalid <= 1'b0;
		while (expected_windows.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0 && expected_windows.size() == 0)
			$display("tb_longest_window_sum_at_most: PASS");
		else
			$display("tb_longest_window_sum_at_most: FAIL");
		$finish;
	end

endmodule
